/* rtl/sha512_pkg.sv */
// SHA-512 shared package: round constants, initial hash, FSM state, command and status types, rotate function.
// No dependencies.
package sha512_pkg;

	localparam logic [63:0] RoundK [80] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

	localparam logic [63:0] StartHash [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
		64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	localparam logic [7:0] PadByte = 8'h80;
	localparam logic [6:0] LastRound = 7'd79;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FINAL,
		ST_PAD,
		ST_EMIT
	} state_t;

	// what a buffer write carries
	typedef enum logic [1:0] {
		WSEL_MSG,
		WSEL_ZERO,
		WSEL_LEN_HI,
		WSEL_LEN_LO
	} wsel_t;

	typedef struct packed {
		logic  take_word;   // select masked input word, bump byte count
		logic  buf_write;   // write a word to the block slot
		wsel_t wsel;
		logic  rnd_start;   // load working vars from chain
		logic  rnd_step;    // one round
		logic  chain_add;   // fold working vars into chain
		logic  reset_msg;   // reload IV, clear byte count and word index
		logic  emit_shift;  // rotate chain for output
	} cmd_t;

	typedef struct packed {
		logic [3:0] word_index;
		logic [6:0] round;
		logic       pad_pending;  // 0x80 word still to be placed
	} stat_t;

	function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (64 - n));
	endfunction

endpackage

/* rtl/sha512_if.sv */
// Valid/ready stream interfaces for message words and digest words.
// Depends on nothing.
interface sha512_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] msg_word;
	logic [3:0]  valid_bytes;
	logic        last_word;
	modport source (output valid, msg_word, valid_bytes, last_word, input ready);
	modport sink (input valid, msg_word, valid_bytes, last_word, output ready);
endinterface

interface sha512_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_word;
	logic        digest_last;
	modport source (output valid, digest_word, digest_last, input ready);
	modport sink (input valid, digest_word, digest_last, output ready);
endinterface

/* rtl/sha512_dp.sv */
// SHA-512 datapath: block buffer, message schedule window, round unit, chain words.
// Depends on sha512_pkg.
module sha512_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  sha512_pkg::cmd_t    cmd,
	input  logic [63:0]         msg_word,
	input  logic [3:0]          valid_bytes,
	input  logic                last_word,
	output sha512_pkg::stat_t   stat,
	output logic [63:0]         digest_word
);
	logic [63:0] buf_q [16];
	logic [63:0] chain_q [8];
	logic [63:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [3:0]  widx_q;
	logic [6:0]  round_q;
	logic [63:0] bytes_q;
	logic        pad_q;
	logic [63:0] word_in;
	logic [3:0]  nb;
	logic [63:0] keep;
	logic [63:0] wval;
	logic [63:0] wr, s0, s1, wnext, t1, t2;

	// clamp byte count, mask unused bytes, place the 0x80 marker
	always_comb begin
		nb = (!last_word) ? 4'd8 : ((valid_bytes > 4'd8) ? 4'd8 : valid_bytes);
		keep = (nb == 4'd0) ? 64'd0 : ~(64'hffff_ffff_ffff_ffff >> {nb, 3'b000});
		word_in = msg_word & keep;
		if (last_word && nb != 4'd8)
			word_in = word_in | ({56'd0, sha512_pkg::PadByte} << ({4'd7 - nb, 3'b000}));
	end

	// select buffer write data
	always_comb begin
		case (cmd.wsel)
			sha512_pkg::WSEL_MSG:    wval = cmd.take_word ? word_in
				: {sha512_pkg::PadByte, 56'd0};
			sha512_pkg::WSEL_ZERO:   wval = 64'd0;
			sha512_pkg::WSEL_LEN_HI: wval = {61'd0, bytes_q[63:61]};
			sha512_pkg::WSEL_LEN_LO: wval = {bytes_q[60:0], 3'b000};
			default:                 wval = 64'd0;
		endcase
	end

	// schedule: buffer acts as a 16-word sliding window during rounds
	always_comb begin
		wr = buf_q[0];
		s0 = sha512_pkg::rotr(buf_q[1], 1) ^ sha512_pkg::rotr(buf_q[1], 8) ^ (buf_q[1] >> 7);
		s1 = sha512_pkg::rotr(buf_q[14], 19) ^ sha512_pkg::rotr(buf_q[14], 61)
			^ (buf_q[14] >> 6);
		wnext = buf_q[0] + s0 + buf_q[9] + s1;
		t1 = h_q + (sha512_pkg::rotr(e_q, 14) ^ sha512_pkg::rotr(e_q, 18)
			^ sha512_pkg::rotr(e_q, 41)) + ((e_q & f_q) ^ (~e_q & g_q))
			+ sha512_pkg::RoundK[round_q] + wr;
		t2 = (sha512_pkg::rotr(a_q, 28) ^ sha512_pkg::rotr(a_q, 34) ^ sha512_pkg::rotr(a_q, 39))
			+ ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));
	end

	// buffer: write slot or shift window
	always_ff @(posedge clk) begin
		if (cmd.buf_write)
			buf_q[widx_q] <= wval;
		else if (cmd.rnd_step) begin
			for (int i = 0; i < 15; i++)
				buf_q[i] <= buf_q[i + 1];
			buf_q[15] <= wnext;
		end
	end

	// working variables
	always_ff @(posedge clk) begin
		if (cmd.rnd_start) begin
			a_q <= chain_q[0]; b_q <= chain_q[1]; c_q <= chain_q[2]; d_q <= chain_q[3];
			e_q <= chain_q[4]; f_q <= chain_q[5]; g_q <= chain_q[6]; h_q <= chain_q[7];
		end else if (cmd.rnd_step) begin
			h_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
			d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
		end
	end

	// control-visible counters and chain words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				chain_q[i] <= sha512_pkg::StartHash[i];
			widx_q  <= 4'd0;
			round_q <= 7'd0;
			bytes_q <= 64'd0;
			pad_q   <= 1'b0;
		end else begin
			if (cmd.take_word) begin
				bytes_q <= bytes_q + {60'd0, nb};
				pad_q   <= last_word && (nb == 4'd8);
			end else if (cmd.buf_write && cmd.wsel == sha512_pkg::WSEL_MSG)
				pad_q <= 1'b0;
			if (cmd.buf_write)
				widx_q <= widx_q + 4'd1;
			if (cmd.rnd_start)
				round_q <= 7'd0;
			else if (cmd.rnd_step)
				round_q <= round_q + 7'd1;
			if (cmd.chain_add) begin
				chain_q[0] <= chain_q[0] + a_q; chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q; chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q; chain_q[5] <= chain_q[5] + f_q;
				chain_q[6] <= chain_q[6] + g_q; chain_q[7] <= chain_q[7] + h_q;
			end else if (cmd.reset_msg) begin
				for (int i = 0; i < 8; i++)
					chain_q[i] <= sha512_pkg::StartHash[i];
				bytes_q <= 64'd0;
				widx_q  <= 4'd0;
			end else if (cmd.emit_shift) begin
				for (int i = 0; i < 7; i++)
					chain_q[i] <= chain_q[i + 1];
				chain_q[7] <= chain_q[0];
			end
		end
	end

	assign stat.word_index  = widx_q;
	assign stat.round       = round_q;
	assign stat.pad_pending = pad_q;
	assign digest_word      = chain_q[0];
endmodule

/* rtl/sha512_ctrl.sv */
// SHA-512 controller: accepts words, sequences padding, rounds and digest output.
// Depends on sha512_pkg.
module sha512_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_last,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               out_last,
	input  sha512_pkg::stat_t  stat,
	output sha512_pkg::cmd_t   cmd
);
	sha512_pkg::state_t state_q, state_d;
	logic       final_q, final_d;   // message ended, padding in progress
	logic [2:0] emit_q, emit_d;
	logic       lenblk_q;           // length words still owed for this message
	logic       hi_q;               // high length word sits in slot 14 of this block

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha512_pkg::ST_IDLE;
			final_q <= 1'b0;
			emit_q  <= 3'd0;
		end else begin
			state_q <= state_d;
			final_q <= final_d;
			emit_q  <= emit_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		final_d   = final_q;
		emit_d    = emit_q;
		cmd       = '0;
		cmd.wsel  = sha512_pkg::WSEL_MSG;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		out_last  = 1'b0;
		case (state_q)
			sha512_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_word = 1'b1;
					cmd.buf_write = 1'b1;
					final_d = in_last;
					if (stat.word_index == 4'd15) begin
						cmd.rnd_start = 1'b1;
						state_d = sha512_pkg::ST_ROUND;
					end else if (in_last)
						state_d = sha512_pkg::ST_PAD;
				end
			end
			sha512_pkg::ST_PAD: begin
				// marker word, zero fill, then length in slots 14 and 15;
				// a marker in slot 14 leaves no room, so slot 15 gets zero
				cmd.buf_write = 1'b1;
				if (stat.pad_pending)
					cmd.wsel = sha512_pkg::WSEL_MSG;
				else if (stat.word_index == 4'd14)
					cmd.wsel = sha512_pkg::WSEL_LEN_HI;
				else if (stat.word_index == 4'd15 && hi_q)
					cmd.wsel = sha512_pkg::WSEL_LEN_LO;
				else
					cmd.wsel = sha512_pkg::WSEL_ZERO;
				if (stat.word_index == 4'd15) begin
					cmd.rnd_start = 1'b1;
					state_d = sha512_pkg::ST_ROUND;
				end
			end
			sha512_pkg::ST_ROUND: begin
				cmd.rnd_step = 1'b1;
				if (stat.round == sha512_pkg::LastRound)
					state_d = sha512_pkg::ST_FINAL;
			end
			sha512_pkg::ST_FINAL: begin
				cmd.chain_add = 1'b1;
				if (!final_q)
					state_d = sha512_pkg::ST_IDLE;
				else if (stat.pad_pending || stat.word_index != 4'd0)
					state_d = sha512_pkg::ST_PAD;
				else if (lenblk_q)
					state_d = sha512_pkg::ST_PAD;
				else begin
					emit_d  = 3'd0;
					state_d = sha512_pkg::ST_EMIT;
				end
			end
			sha512_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				out_last  = (emit_q == 3'd7);
				if (out_ready) begin
					cmd.emit_shift = 1'b1;
					emit_d = emit_q + 3'd1;
					if (emit_q == 3'd7) begin
						cmd.emit_shift = 1'b0;
						cmd.reset_msg  = 1'b1;
						final_d = 1'b0;
						state_d = sha512_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = sha512_pkg::ST_IDLE;
		endcase
	end

	// length still to be written in this message: clears on the block that carries it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			lenblk_q <= 1'b0;
		else if (cmd.take_word && in_last)
			lenblk_q <= 1'b1;
		else if (cmd.buf_write && cmd.wsel == sha512_pkg::WSEL_LEN_LO)
			lenblk_q <= 1'b0;
	end

	// track the high length word until the block closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hi_q <= 1'b0;
		else if (cmd.buf_write && cmd.wsel == sha512_pkg::WSEL_LEN_HI)
			hi_q <= 1'b1;
		else if (cmd.buf_write && stat.word_index == 4'd15)
			hi_q <= 1'b0;
	end
endmodule

/* rtl/sha512_stream_hasher.sv */
// SHA-512 stream hasher top level: controller plus datapath behind two stream ports.
// Depends on sha512_pkg, sha512_if, sha512_ctrl, sha512_dp.
//
//  port      dir   payload                                  note
//  msg_in    sink  msg_word[64] valid_bytes[4] last_word[1] big-endian words
//  dig_out   src   digest_word[64] digest_last[1]           H0 first, last flag on H7
//
// Words are taken back to back while idle; the sixteenth word of a block starts the rounds
// in the shared round unit and then the fold into the chain, with input stalled meanwhile.
// The last word adds padding writes (up to 16 per block), one or two compressions and
// eight digest beats. Reset reloads the initial hash; no clearing pass.
// Input stalls while padding, compressing or emitting; the digest holds while dig_out.ready
// is low.
module sha512_stream_hasher (
	input logic      clk,
	input logic      arst_n,
	sha512_in_if.sink    msg_in,
	sha512_out_if.source dig_out
);
	sha512_pkg::cmd_t  cmd;
	sha512_pkg::stat_t stat;

	sha512_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (msg_in.valid),
		.in_last   (msg_in.last_word),
		.in_ready  (msg_in.ready),
		.out_valid (dig_out.valid),
		.out_ready (dig_out.ready),
		.out_last  (dig_out.digest_last),
		.stat      (stat),
		.cmd       (cmd)
	);

	sha512_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.msg_word    (msg_in.msg_word),
		.valid_bytes (msg_in.valid_bytes),
		.last_word   (msg_in.last_word),
		.stat        (stat),
		.digest_word (dig_out.digest_word)
	);
endmodule

/* rtl/sha512_chk.sv */
// Port-level checker for the SHA-512 stream hasher, bound to the top level.
// The bind depends on sha512_stream_hasher and its sha512_if ports.
module sha512_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic        out_last,
	input logic [63:0] out_word
);
	// no input taken while a digest is shown
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input open during digest");

	// a stalled digest word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_last))
		else $error("digest changed under stall");

	// input closes after a last word
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready) else $error("ready after last");

	// after the final digest beat, no digest follows directly
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last |=> !out_valid) else $error("extra digest");
endmodule

bind sha512_stream_hasher sha512_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (msg_in.valid),
	.in_ready  (msg_in.ready),
	.in_last   (msg_in.last_word),
	.out_valid (dig_out.valid),
	.out_ready (dig_out.ready),
	.out_last  (dig_out.digest_last),
	.out_word  (dig_out.digest_word)
);
